@@ hw/rtl/sarc_pkg.sv @@
package sarc_pkg;

    localparam int SETS_MAX   = 1024;
    localparam int WAYS_MAX   = 8;
    localparam int ENTRIES    = SETS_MAX * WAYS_MAX;

    localparam int SET_W      = $clog2(SETS_MAX);
    localparam int WAY_W      = 3;
    localparam int ENTRY_W    = 13;
    localparam int NSETS_W    = 11;
    localparam int NWAYS_W    = 4;
    localparam int ROW_W      = 32;
    localparam int TAG_W      = 33;
    localparam int STAMP_W    = 32;
    localparam int MARK_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DIV_CNT_W  = $clog2(ROW_W);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_PEEK   = 2'd1,
        OP_FILL   = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    localparam logic [MARK_W-1:0] MARK_CLEAR = 2'd0;
    localparam logic [MARK_W-1:0] MARK_SEEN  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_ADMIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SETS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_WAYS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADMIT    = 2'd2;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic div_step;
        logic rd;
        logic cmp;
        logic upd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_flush;
        logic is_flush;
        logic clr_last;
        logic div_last;
        logic way_last;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/sarc_ram.sv @@
module sarc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sarc_ctrl.sv @@
module sarc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sarc_pkg::t_status i_status,
    output sarc_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_RD    = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = i_status.is_flush ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.in_flush ? S_CLEAR : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = i_status.way_last ? S_UPD : S_RD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ hw/rtl/sarc_dpath.sv @@
module sarc_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sarc_pkg::t_cmd                     i_cmd,
    output sarc_pkg::t_status                  o_status,
    input  logic                               i_cfg_valid,
    input  logic [sarc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sarc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [1:0]                         i_op,
    input  logic [sarc_pkg::ROW_W-1:0]         i_row_id,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_hit,
    output logic                               o_filled,
    output logic [sarc_pkg::WAY_W-1:0]         o_way_index,
    output logic [sarc_pkg::ENTRY_W-1:0]       o_entry_index
);

    // configuration
    logic [sarc_pkg::NSETS_W-1:0] r_num_sets;
    logic [sarc_pkg::NWAYS_W-1:0] r_num_ways;
    logic                         r_admit;
    logic [sarc_pkg::NSETS_W-1:0] sets_used;
    logic [sarc_pkg::NWAYS_W-1:0] ways_used;
    logic [sarc_pkg::WAY_W-1:0]   ways_last;

    // item
    sarc_pkg::t_op                r_op;
    logic [sarc_pkg::ROW_W-1:0]   r_row;
    logic [sarc_pkg::TAG_W-1:0]   tag;

    // control flags
    logic [sarc_pkg::ENTRY_W-1:0] r_clr_cnt;
    logic                         r_clr_stamps;
    logic                         r_flush;
    logic                         clr_last;

    // remainder unit
    logic [sarc_pkg::SET_W-1:0]     r_rem;
    logic [sarc_pkg::ROW_W-1:0]     r_dvd;
    logic [sarc_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [sarc_pkg::SET_W:0]       rem_sh;
    logic [sarc_pkg::SET_W-1:0]     n_rem;

    // scan
    logic [sarc_pkg::WAY_W-1:0]   r_way;
    logic                         r_match_found;
    logic [sarc_pkg::WAY_W-1:0]   r_match_way;
    logic                         r_empty_found;
    logic [sarc_pkg::WAY_W-1:0]   r_empty_way;
    logic [sarc_pkg::STAMP_W-1:0] r_min_stamp;
    logic [sarc_pkg::WAY_W-1:0]   r_min_way;
    logic                         r_tag0_eq;
    logic [sarc_pkg::ENTRY_W-1:0] base;
    logic [sarc_pkg::ENTRY_W-1:0] entry_rd;
    logic                         tag_eq;
    logic                         tag_empty;

    // update
    logic                         is_fill;
    logic                         decline;
    logic [sarc_pkg::WAY_W-1:0]   fill_way;
    logic [sarc_pkg::ENTRY_W-1:0] fill_entry;
    logic [sarc_pkg::ENTRY_W-1:0] hit_entry;
    logic                         stamp_upd;
    logic [sarc_pkg::STAMP_W-1:0] r_use_clock;
    logic [sarc_pkg::STAMP_W-1:0] n_clock;

    // results
    logic                         r_res_hit;
    logic                         r_res_filled;
    logic [sarc_pkg::WAY_W-1:0]   r_res_way;
    logic [sarc_pkg::ENTRY_W-1:0] r_res_entry;
    logic                         r_out_valid;
    logic                         r_hit;
    logic                         r_filled;
    logic [sarc_pkg::WAY_W-1:0]   r_way_index;
    logic [sarc_pkg::ENTRY_W-1:0] r_entry_index;

    // memories
    logic                         tag_we;
    logic [sarc_pkg::ENTRY_W-1:0] tag_waddr;
    logic [sarc_pkg::TAG_W-1:0]   tag_wdata;
    logic [sarc_pkg::TAG_W-1:0]   tag_rdata;
    logic                         stamp_we;
    logic [sarc_pkg::ENTRY_W-1:0] stamp_waddr;
    logic [sarc_pkg::STAMP_W-1:0] stamp_wdata;
    logic [sarc_pkg::STAMP_W-1:0] stamp_rdata;
    logic                         mark_we;
    logic [sarc_pkg::SET_W-1:0]   mark_waddr;
    logic [sarc_pkg::MARK_W-1:0]  mark_wdata;
    logic [sarc_pkg::MARK_W-1:0]  mark_rdata;

    always_comb begin
        if (r_num_sets == '0) begin
            sets_used = sarc_pkg::NSETS_W'(1);
        end else if (r_num_sets > sarc_pkg::NSETS_W'(sarc_pkg::SETS_MAX)) begin
            sets_used = sarc_pkg::NSETS_W'(sarc_pkg::SETS_MAX);
        end else begin
            sets_used = r_num_sets;
        end
        if (r_num_ways == '0) begin
            ways_used = sarc_pkg::NWAYS_W'(1);
        end else if (r_num_ways > sarc_pkg::NWAYS_W'(sarc_pkg::WAYS_MAX)) begin
            ways_used = sarc_pkg::NWAYS_W'(sarc_pkg::WAYS_MAX);
        end else begin
            ways_used = r_num_ways;
        end
    end

    assign ways_last = sarc_pkg::WAY_W'(ways_used - sarc_pkg::NWAYS_W'(1));
    assign tag       = {1'b0, r_row} + sarc_pkg::TAG_W'(1);
    assign clr_last  = (r_clr_cnt == sarc_pkg::ENTRY_W'(sarc_pkg::ENTRIES - 1));

    // one quotient bit per cycle, remainder always below the set count
    assign rem_sh = {r_rem, r_dvd[sarc_pkg::ROW_W-1]};
    assign n_rem  = (rem_sh >= sets_used) ? sarc_pkg::SET_W'(rem_sh - sets_used)
                                          : sarc_pkg::SET_W'(rem_sh);

    assign base      = sarc_pkg::ENTRY_W'(r_rem) * sarc_pkg::ENTRY_W'(ways_used);
    assign entry_rd  = base + sarc_pkg::ENTRY_W'(r_way);
    assign tag_eq    = (tag_rdata == tag);
    assign tag_empty = (tag_rdata == '0);

    assign is_fill    = (r_op == sarc_pkg::OP_FILL);
    assign decline    = r_admit && !r_tag0_eq && (mark_rdata == sarc_pkg::MARK_CLEAR);
    assign fill_way   = r_match_found ? r_match_way :
                        r_empty_found ? r_empty_way : r_min_way;
    assign fill_entry = base + sarc_pkg::ENTRY_W'(fill_way);
    assign hit_entry  = base + sarc_pkg::ENTRY_W'(r_match_way);
    assign n_clock    = r_use_clock + sarc_pkg::STAMP_W'(1);
    assign stamp_upd  = i_cmd.upd && ((is_fill && !decline) ||
                        (r_op == sarc_pkg::OP_LOOKUP && r_match_found));

    always_comb begin
        tag_we      = i_cmd.clear_step || (i_cmd.upd && is_fill && !decline);
        tag_waddr   = i_cmd.clear_step ? r_clr_cnt : fill_entry;
        tag_wdata   = i_cmd.clear_step ? '0 : tag;
        stamp_we    = (i_cmd.clear_step && r_clr_stamps) || stamp_upd;
        stamp_waddr = i_cmd.clear_step ? r_clr_cnt : (is_fill ? fill_entry : hit_entry);
        stamp_wdata = i_cmd.clear_step ? '0 : n_clock;
        mark_we     = i_cmd.clear_step || (i_cmd.upd && is_fill && (decline || r_admit));
        mark_waddr  = i_cmd.clear_step ? r_clr_cnt[sarc_pkg::SET_W-1:0] : r_rem;
        if (i_cmd.clear_step) begin
            mark_wdata = sarc_pkg::MARK_CLEAR;
        end else if (decline) begin
            mark_wdata = sarc_pkg::MARK_SEEN;
        end else begin
            mark_wdata = sarc_pkg::MARK_ADMIT;
        end
    end

    sarc_ram #(.WIDTH(sarc_pkg::TAG_W), .DEPTH(sarc_pkg::ENTRIES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (entry_rd),
        .o_rdata (tag_rdata)
    );

    sarc_ram #(.WIDTH(sarc_pkg::STAMP_W), .DEPTH(sarc_pkg::ENTRIES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (stamp_waddr),
        .i_wdata (stamp_wdata),
        .i_raddr (entry_rd),
        .o_rdata (stamp_rdata)
    );

    sarc_ram #(.WIDTH(sarc_pkg::MARK_W), .DEPTH(sarc_pkg::SETS_MAX)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (r_rem),
        .o_rdata (mark_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_sets   <= sarc_pkg::NSETS_W'(sarc_pkg::SETS_MAX);
            r_num_ways   <= sarc_pkg::NWAYS_W'(1);
            r_admit      <= 1'b0;
            r_clr_cnt    <= '0;
            r_clr_stamps <= 1'b1;
            r_flush      <= 1'b0;
            r_use_clock  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sarc_pkg::CFG_NUM_SETS: r_num_sets <= i_cfg_data;
                    sarc_pkg::CFG_NUM_WAYS: r_num_ways <= i_cfg_data[sarc_pkg::NWAYS_W-1:0];
                    sarc_pkg::CFG_ADMIT:    r_admit    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.clear_step) begin
                r_clr_cnt <= clr_last ? '0 : r_clr_cnt + sarc_pkg::ENTRY_W'(1);
                if (clr_last) begin
                    r_clr_stamps <= 1'b0;
                end
            end
            if (i_cmd.accept) begin
                r_flush <= (i_op == sarc_pkg::OP_FLUSH);
            end else if (i_cmd.load_out) begin
                r_flush <= 1'b0;
            end
            if (stamp_upd) begin
                r_use_clock <= n_clock;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op          <= sarc_pkg::t_op'(i_op);
            r_row         <= i_row_id;
            r_rem         <= '0;
            r_dvd         <= i_row_id;
            r_div_cnt     <= '1;
            r_way         <= '0;
            r_match_found <= 1'b0;
            r_match_way   <= '0;
            r_empty_found <= 1'b0;
            r_empty_way   <= '0;
            r_min_stamp   <= '1;
            r_min_way     <= '0;
            r_tag0_eq     <= 1'b0;
            r_res_hit     <= 1'b0;
            r_res_filled  <= 1'b0;
            r_res_way     <= '0;
            r_res_entry   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= n_rem;
            r_dvd     <= {r_dvd[sarc_pkg::ROW_W-2:0], 1'b0};
            r_div_cnt <= r_div_cnt - sarc_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.cmp) begin
            if (tag_eq && !r_match_found) begin
                r_match_found <= 1'b1;
                r_match_way   <= r_way;
            end
            if (tag_empty && !r_empty_found) begin
                r_empty_found <= 1'b1;
                r_empty_way   <= r_way;
            end
            // strict compare keeps the lowest way on ties
            if (stamp_rdata < r_min_stamp) begin
                r_min_stamp <= stamp_rdata;
                r_min_way   <= r_way;
            end
            if (r_way == '0) begin
                r_tag0_eq <= tag_eq;
            end
            if (r_way != ways_last) begin
                r_way <= r_way + sarc_pkg::WAY_W'(1);
            end
        end
        if (i_cmd.upd) begin
            if (is_fill) begin
                r_res_hit    <= 1'b0;
                r_res_filled <= !decline;
                r_res_way    <= decline ? '0 : fill_way;
                r_res_entry  <= decline ? '0 : fill_entry;
            end else begin
                r_res_hit    <= r_match_found;
                r_res_filled <= 1'b0;
                r_res_way    <= r_match_found ? r_match_way : '0;
                r_res_entry  <= r_match_found ? hit_entry : '0;
            end
        end
        if (i_cmd.load_out) begin
            r_hit         <= r_res_hit;
            r_filled      <= r_res_filled;
            r_way_index   <= r_res_way;
            r_entry_index <= r_res_entry;
        end
    end

    always_comb begin
        o_status          = '0;
        o_status.in_flush = (i_op == sarc_pkg::OP_FLUSH);
        o_status.is_flush = r_flush;
        o_status.clr_last = clr_last;
        o_status.div_last = (r_div_cnt == '0);
        o_status.way_last = (r_way == ways_last);
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_filled      = r_filled;
    assign o_way_index   = r_way_index;
    assign o_entry_index = r_entry_index;

    a_rem_below_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> (sarc_pkg::NSETS_W'(r_rem) < sets_used))
        else $error("remainder not below set count");

    a_way_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.upd) |-> (r_res_way <= $past(ways_last)))
        else $error("result way beyond ways in use");

    a_clock_only_on_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(stamp_upd)) |-> $stable(r_use_clock))
        else $error("use clock moved without a stamp write");

    a_no_stamp_on_peek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.upd && r_op == sarc_pkg::OP_PEEK) |-> !stamp_we)
        else $error("peek wrote a stamp");

endmodule

@@ hw/rtl/set_assoc_row_cache_tags_unit.sv @@
// Lookup, peek and fill: a 32-step remainder unit picks the set, then one tag/stamp
// read per way in use, an update, and the result goes to the output register.
// One item at a time; the next is taken once the result sits in the output register.
// Flush: one tag/mark clear per cycle, then the result.
// Synchronous reset, then a clearing pass over all tags, stamps and marks
// during which no item is taken; configuration writes are taken at any time.
module set_assoc_row_cache_tags_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sarc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sarc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_op,
    input  logic [sarc_pkg::ROW_W-1:0]      i_row_id,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_hit,
    output logic                            o_filled,
    output logic [sarc_pkg::WAY_W-1:0]      o_way_index,
    output logic [sarc_pkg::ENTRY_W-1:0]    o_entry_index
);

    sarc_pkg::t_cmd    cmd;
    sarc_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    sarc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    sarc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_row_id      (i_row_id),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_hit         (o_hit),
        .o_filled      (o_filled),
        .o_way_index   (o_way_index),
        .o_entry_index (o_entry_index)
    );

endmodule
